[design/obbsat_pkg.sv]
// Shared constants, command codes and types for the oriented-box overlap test.
// Used by obbsat_ctrl, obbsat_dp and obb_separating_axis_test; no dependencies.
package obbsat_pkg;

  // Coordinate width of one vector component (signed fixed point).
  localparam int COORD_WIDTH = 24;
  // Width of a candidate axis component: a difference of two full products.
  localparam int LW          = 2 * COORD_WIDTH + 1;
  // Multiplier operand width: holds an axis slice, a center difference or a vector.
  localparam int MW          = COORD_WIDTH + 2;
  localparam int PW          = 2 * MW;
  // Accumulator width: a sum of six absolute dot products of an axis and a vector.
  localparam int ACC_W       = 3 * COORD_WIDTH + 8;

  localparam int NUM_SLOTS   = 7;
  localparam logic [3:0] LAST_AXIS  = 4'd14;
  localparam logic [3:0] FACE_AXES  = 4'd6;
  localparam logic [2:0] LAST_VEC   = 3'd6;
  localparam logic [2:0] FOLD_STEP  = 3'd6;
  localparam logic [2:0] LAST_LSTEP = 3'd5;

  localparam logic [2:0] SLOT_CENTER = 3'd0;
  localparam logic [2:0] SLOT_AXIS0  = 3'd1;
  localparam logic [2:0] SLOT_HALF0  = 3'd4;
  localparam logic [2:0] SLOT_NONE   = 3'd7;

  localparam logic OPER_LOAD = 1'b0;
  localparam logic OPER_TEST = 1'b1;

  // Datapath command codes.
  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_PREP      = 4'd2;
  localparam logic [3:0] OP_FACE      = 4'd3;
  localparam logic [3:0] OP_CROSS_A   = 4'd4;
  localparam logic [3:0] OP_CROSS_B   = 4'd5;
  localparam logic [3:0] OP_DOT_FIRST = 4'd6;
  localparam logic [3:0] OP_DOT_LO    = 4'd7;
  localparam logic [3:0] OP_DOT_HI    = 4'd8;
  localparam logic [3:0] OP_FOLD_D    = 4'd9;
  localparam logic [3:0] OP_FOLD_H    = 4'd10;
  localparam logic [3:0] OP_CMP       = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic       box;
    logic [2:0] slot;
    logic [1:0] ax_i;
    logic [1:0] ax_j;
    logic [1:0] ca;
    logic [1:0] cb;
    logic [1:0] comp;
    logic [2:0] vsel;
  } dp_cmd_t;

  typedef struct packed {
    logic sep;
  } dp_stat_t;

  function automatic logic [1:0] next_comp(input logic [1:0] k);
    next_comp = (k == 2'd2) ? 2'd0 : k + 2'd1;
  endfunction

  // Box 0 face axis index of a cross-product candidate axis.
  function automatic logic [1:0] cross_i(input logic [3:0] axis);
    case (axis)
      4'd6, 4'd7, 4'd8:    cross_i = 2'd0;
      4'd9, 4'd10, 4'd11:  cross_i = 2'd1;
      default:             cross_i = 2'd2;
    endcase
  endfunction

  // Box 1 face axis index of a cross-product candidate axis.
  function automatic logic [1:0] cross_j(input logic [3:0] axis);
    case (axis)
      4'd6, 4'd9, 4'd12:   cross_j = 2'd0;
      4'd7, 4'd10, 4'd13:  cross_j = 2'd1;
      default:             cross_j = 2'd2;
    endcase
  endfunction

endpackage

[design/obbsat_dp.sv]
// Datapath of the overlap test: box vector storage, shared multiplier and
// accumulator. Depends on obbsat_pkg; driven by obbsat_ctrl commands.
module obbsat_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  obbsat_pkg::dp_cmd_t                    cmd,
  input  logic signed [obbsat_pkg::COORD_WIDTH-1:0] vec_x,
  input  logic signed [obbsat_pkg::COORD_WIDTH-1:0] vec_y,
  input  logic signed [obbsat_pkg::COORD_WIDTH-1:0] vec_z,
  output obbsat_pkg::dp_stat_t                   stat
);
  import obbsat_pkg::*;

  logic signed [COORD_WIDTH-1:0] c_r  [2][3];
  logic signed [COORD_WIDTH-1:0] ax_r [2][3][3];
  logic signed [COORD_WIDTH-1:0] hx_r [2][3][3];
  logic signed [COORD_WIDTH-1:0] new_v [3];
  logic signed [COORD_WIDTH:0]   d_r  [3];
  logic signed [LW-1:0]          l_r  [3];
  logic signed [ACC_W-1:0]       acc_r, dabs_r, rsum_r;
  logic                          sep_r;
  dp_cmd_t                       cmd_r;
  logic signed [PW-1:0]          prod_r;

  logic signed [MW-1:0]    ma, mb;
  logic signed [PW-1:0]    prod;
  logic                    hbox;
  logic [1:0]              hidx;
  logic signed [ACC_W-1:0] prod_ext, prod_sh, acc_abs;

  assign new_v[0] = vec_x;
  assign new_v[1] = vec_y;
  assign new_v[2] = vec_z;

  // Vector storage, written as soon as a load transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      for (int k = 0; k < 3; k++) begin
        if (cmd.slot == SLOT_CENTER) begin
          c_r[cmd.box][k] <= new_v[k];
        end else if (cmd.slot < SLOT_HALF0) begin
          ax_r[cmd.box][2'(cmd.slot - SLOT_AXIS0)][k] <= new_v[k];
        end else if (cmd.slot != SLOT_NONE) begin
          hx_r[cmd.box][2'(cmd.slot - SLOT_HALF0)][k] <= new_v[k];
        end
      end
    end
  end

  // First stage: operand selection and the shared multiplier.
  always_comb begin
    hbox = (cmd.vsel >= SLOT_HALF0);
    hidx = hbox ? 2'(cmd.vsel - SLOT_HALF0) : 2'(cmd.vsel - SLOT_AXIS0);
    ma   = '0;
    mb   = '0;
    case (cmd.op)
      OP_CROSS_A, OP_CROSS_B: begin
        ma = MW'(ax_r[0][cmd.ax_i][cmd.ca]);
        mb = MW'(ax_r[1][cmd.ax_j][cmd.cb]);
      end
      OP_DOT_FIRST, OP_DOT_LO, OP_DOT_HI: begin
        if (cmd.op == OP_DOT_HI) begin
          ma = MW'(l_r[cmd.comp] >>> COORD_WIDTH);
        end else begin
          ma = $signed({2'b00, l_r[cmd.comp][COORD_WIDTH-1:0]});
        end
        if (cmd.vsel == SLOT_CENTER) begin
          mb = MW'(d_r[cmd.comp]);
        end else begin
          mb = MW'(hx_r[hbox][hidx][cmd.comp]);
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r.op <= OP_NOP;
    end else begin
      cmd_r.op <= cmd.op;
    end
    cmd_r.box  <= cmd.box;
    cmd_r.slot <= cmd.slot;
    cmd_r.ax_i <= cmd.ax_i;
    cmd_r.ax_j <= cmd.ax_j;
    cmd_r.ca   <= cmd.ca;
    cmd_r.cb   <= cmd.cb;
    cmd_r.comp <= cmd.comp;
    cmd_r.vsel <= cmd.vsel;
    prod_r     <= prod;
  end

  assign prod_ext = ACC_W'(prod_r);
  assign prod_sh  = prod_ext <<< COORD_WIDTH;
  assign acc_abs  = acc_r[ACC_W-1] ? -acc_r : acc_r;

  // Second stage: accumulate, build the axis, fold and compare.
  always_ff @(posedge clk) begin
    case (cmd_r.op)
      OP_PREP: begin
        for (int k = 0; k < 3; k++) begin
          d_r[k] <= (COORD_WIDTH+1)'(c_r[1][k]) - (COORD_WIDTH+1)'(c_r[0][k]);
        end
      end
      OP_FACE: begin
        for (int k = 0; k < 3; k++) begin
          l_r[k] <= LW'(ax_r[cmd_r.box][cmd_r.ax_i][k]);
        end
      end
      OP_CROSS_A, OP_DOT_FIRST: acc_r <= prod_ext;
      OP_CROSS_B:               l_r[cmd_r.comp] <= LW'(acc_r - prod_ext);
      OP_DOT_LO:                acc_r <= acc_r + prod_ext;
      OP_DOT_HI:                acc_r <= acc_r + prod_sh;
      OP_FOLD_D: begin
        dabs_r <= acc_abs;
        rsum_r <= '0;
      end
      OP_FOLD_H:                rsum_r <= rsum_r + acc_abs;
      OP_CMP:                   sep_r <= (dabs_r > rsum_r);
      default: begin
      end
    endcase
  end

  assign stat.sep = sep_r;

endmodule

[design/obbsat_ctrl.sv]
// Controller of the overlap test: load bookkeeping, axis sequencing and the
// result register. Depends on obbsat_pkg; commands obbsat_dp.
module obbsat_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 operation,
  input  logic                 box_sel,
  input  logic [2:0]           slot,
  input  obbsat_pkg::dp_stat_t stat,
  output obbsat_pkg::dp_cmd_t  cmd,
  output logic                 busy,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic                 out_incomplete
);
  import obbsat_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_LGEN   = 3'd2;
  localparam logic [2:0] ST_BUBBLE = 3'd3;
  localparam logic [2:0] ST_DOTS   = 3'd4;
  localparam logic [2:0] ST_CMP    = 3'd5;
  localparam logic [2:0] ST_WAIT   = 3'd6;
  localparam logic [2:0] ST_DECIDE = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [3:0]           axis_r, axis_nxt;
  logic [2:0]           sub_r, sub_nxt;
  logic [2:0]           vec_r, vec_nxt;
  logic [NUM_SLOTS-1:0] loaded_r [2];
  logic [NUM_SLOTS-1:0] loaded_nxt [2];
  logic                 valid_r, valid_nxt;
  logic                 hit_r, hit_nxt;
  logic                 inc_r, inc_nxt;
  logic [1:0]           p, q, lcomp;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    sub_nxt       = sub_r;
    vec_nxt       = vec_r;
    loaded_nxt[0] = loaded_r[0];
    loaded_nxt[1] = loaded_r[1];
    valid_nxt     = 1'b0;
    hit_nxt       = hit_r;
    inc_nxt       = inc_r;
    cmd           = '0;
    cmd.op        = OP_NOP;
    lcomp         = sub_r[2:1];
    p             = next_comp(lcomp);
    q             = next_comp(p);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (operation == OPER_LOAD) begin
            cmd.op   = OP_LOAD;
            cmd.box  = box_sel;
            cmd.slot = slot;
            if (slot != SLOT_NONE) begin
              loaded_nxt[box_sel] = loaded_r[box_sel] | (NUM_SLOTS'(1) << slot);
            end
          end else if ((&loaded_r[0]) && (&loaded_r[1])) begin
            axis_nxt  = '0;
            state_nxt = ST_PREP;
          end else begin
            valid_nxt = 1'b1;
            hit_nxt   = 1'b0;
            inc_nxt   = 1'b1;
          end
        end
      end
      ST_PREP: begin
        cmd.op    = OP_PREP;
        sub_nxt   = '0;
        state_nxt = ST_LGEN;
      end
      ST_LGEN: begin
        if (axis_r < FACE_AXES) begin
          cmd.op    = OP_FACE;
          cmd.box   = (axis_r >= 4'd3);
          cmd.ax_i  = (axis_r >= 4'd3) ? 2'(axis_r - 4'd3) : axis_r[1:0];
          state_nxt = ST_BUBBLE;
        end else begin
          cmd.op   = sub_r[0] ? OP_CROSS_B : OP_CROSS_A;
          cmd.ax_i = cross_i(axis_r);
          cmd.ax_j = cross_j(axis_r);
          cmd.comp = lcomp;
          cmd.ca   = sub_r[0] ? q : p;
          cmd.cb   = sub_r[0] ? p : q;
          sub_nxt  = sub_r + 3'd1;
          if (sub_r == LAST_LSTEP) begin
            state_nxt = ST_BUBBLE;
          end
        end
      end
      ST_BUBBLE: begin
        sub_nxt   = '0;
        vec_nxt   = '0;
        state_nxt = ST_DOTS;
      end
      ST_DOTS: begin
        cmd.vsel = vec_r;
        cmd.comp = sub_r[2:1];
        if (sub_r == FOLD_STEP) begin
          cmd.op  = (vec_r == SLOT_CENTER) ? OP_FOLD_D : OP_FOLD_H;
          sub_nxt = '0;
          vec_nxt = vec_r + 3'd1;
          if (vec_r == LAST_VEC) begin
            state_nxt = ST_CMP;
          end
        end else begin
          if (sub_r == 3'd0) begin
            cmd.op = OP_DOT_FIRST;
          end else if (sub_r[0]) begin
            cmd.op = OP_DOT_HI;
          end else begin
            cmd.op = OP_DOT_LO;
          end
          sub_nxt = sub_r + 3'd1;
        end
      end
      ST_CMP: begin
        cmd.op    = OP_CMP;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat.sep || axis_r == LAST_AXIS) begin
          valid_nxt = 1'b1;
          hit_nxt   = !stat.sep;
          inc_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          axis_nxt  = axis_r + 4'd1;
          sub_nxt   = '0;
          state_nxt = ST_LGEN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r[0] <= '0;
      loaded_r[1] <= '0;
      valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r[0] <= loaded_nxt[0];
      loaded_r[1] <= loaded_nxt[1];
      valid_r     <= valid_nxt;
    end
    axis_r <= axis_nxt;
    sub_r  <= sub_nxt;
    vec_r  <= vec_nxt;
    hit_r  <= hit_nxt;
    inc_r  <= inc_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = valid_r;
  assign out_hit        = hit_r;
  assign out_incomplete = inc_r;

endmodule

[design/obb_separating_axis_test.sv]
// Oriented-box overlap test by separating axes, top level.
// A load transaction gives no result and leaves busy low; the next transaction can
// follow in the next cycle. A test transaction on incomplete boxes puts its result
// on the ports in the cycle right after acceptance and leaves busy low. Otherwise
// busy stays high while one shared multiplier walks 15 axes, stopping at the first
// separating axis, and the result is on the ports in the first cycle with busy low
// again. The result strobe is high for one cycle and cannot be stalled by the
// receiver. Reset (rst_n, synchronous) clears the controller state, the result
// strobe and the loaded-slot flags.
module obb_separating_axis_test (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  output logic                                      busy,
  input  logic                                      in_operation,
  input  logic                                      in_box_sel,
  input  logic [2:0]                                in_slot,
  input  logic signed [obbsat_pkg::COORD_WIDTH-1:0] in_vec_x,
  input  logic signed [obbsat_pkg::COORD_WIDTH-1:0] in_vec_y,
  input  logic signed [obbsat_pkg::COORD_WIDTH-1:0] in_vec_z,
  output logic                                      out_valid,
  output logic                                      out_hit,
  output logic                                      out_incomplete
);
  import obbsat_pkg::*;

  // The controller sequences every candidate axis as a list of commands: the
  // axis is built (copied for a face axis, or six products for a cross axis),
  // then each of the seven vectors (center difference and six half extents)
  // is projected onto it with six partial products and folded into the sums.
  // The datapath runs each command in two stages, multiply then accumulate,
  // and the controller idles (ST_BUBBLE, ST_WAIT) before axis or verdict is read.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  obbsat_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .operation      (in_operation),
    .box_sel        (in_box_sel),
    .slot           (in_slot),
    .stat           (stat),
    .cmd            (cmd),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_incomplete (out_incomplete)
  );

  // Vector storage, the shared multiplier and the accumulators.
  obbsat_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .vec_x (in_vec_x),
    .vec_y (in_vec_y),
    .vec_z (in_vec_z),
    .stat  (stat)
  );

endmodule
